// File: hw/rtl/sapq_pkg.sv
// shared types and constants for the sorted array priority queue
// no dependencies

package sapq_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	// operation codes carried by func
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;     // take an input beat and register its result
		logic do_ins;   // insert key into the sorted cells
		logic do_rem;   // drop the front cell
		logic acc;      // operation accepted
	} sapq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} sapq_stat_t;

endpackage

// File: hw/rtl/sapq_ctrl.sv
// controller: handshakes, accept decision and result-pending state
// depends on sapq_pkg

module sapq_ctrl import sapq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	output logic       out_valid,
	input  logic       out_ready,
	input  sapq_stat_t stat,
	output sapq_cmd_t  cmd
);

	typedef enum logic {
		ST_EMPTY,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   beat;

	// output register frees on the same edge it is taken
	assign in_ready = (state_q == ST_EMPTY) || out_ready;
	assign beat     = in_valid && in_ready;

	always_comb begin
		cmd        = '0;
		cmd.load   = beat;
		cmd.do_ins = beat && (func == FUNC_INSERT) && !stat.full;
		cmd.do_rem = beat && (func == FUNC_REMOVE) && !stat.empty;
		cmd.acc    = cmd.do_ins || cmd.do_rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			case (state_q)
				ST_EMPTY: begin
					if (beat) state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_ready && !beat) state_q <= ST_EMPTY;
				end
				default: state_q <= ST_EMPTY;
			endcase
		end
	end

	assign out_valid = (state_q == ST_HOLD);

endmodule

// File: hw/rtl/sapq_dp.sv
// datapath: row of compare-and-shift cells, entry count and result registers
// depends on sapq_pkg

module sapq_dp import sapq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sapq_cmd_t            cmd,
	input  logic [31:0]          key_in,
	output sapq_stat_t           stat,
	output logic                 accepted,
	output logic [31:0]          front_key,
	output logic                 not_empty,
	output logic [CNT_W-1:0]     entry_count
);

	logic [KEY_WIDTH-1:0] cell_q [CAPACITY];
	logic [KEY_WIDTH-1:0] cell_nxt [CAPACITY];
	logic [CAPACITY-1:0]  ge;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic [KEY_WIDTH-1:0] key;

	assign key        = key_in[KEY_WIDTH-1:0];
	assign stat.full  = (count_q == CNT_W'(CAPACITY));
	assign stat.empty = (count_q == '0);

	// cell holds a key that stays ahead of the new one
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ge[i] = (CNT_W'(i) < count_q) && (cell_q[i] >= key);
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_nxt[i] = cell_q[i];
			if (cmd.do_ins && !ge[i]) begin
				if (i == 0) cell_nxt[i] = key;
				else if (ge[i-1]) cell_nxt[i] = key;
				else cell_nxt[i] = cell_q[i-1];
			end else if (cmd.do_rem && (i < CAPACITY - 1)) begin
				cell_nxt[i] = cell_q[i+1];
			end
		end
		count_nxt = count_q;
		if (cmd.do_ins) count_nxt = count_q + 1'b1;
		else if (cmd.do_rem) count_nxt = count_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_q[i] <= cell_nxt[i];
		end
		if (cmd.load) begin
			accepted    <= cmd.acc;
			not_empty   <= (count_nxt != '0);
			entry_count <= count_nxt;
			front_key   <= (count_nxt != '0) ? 32'(cell_nxt[0]) : '0;
		end
	end

endmodule

// File: hw/rtl/sorted_array_priority_queue_unit.sv
// Bounded max-priority queue of 16 keys of 32 bits, kept sorted in a row of
// compare-and-shift cells with the front key always in the first cell. Every
// input beat (func 0 insert, 1 remove front) is applied to the cells and
// gives one result beat: accepted, front key, non-empty flag and entry count
// after the operation. One item per clock is sustained while out_ready is
// high; the result waits in an output register, and a new input beat is taken
// on the edge the result beat leaves. Equal keys leave in arrival order.
// depends on sapq_pkg, sapq_ctrl, sapq_dp

module sorted_array_priority_queue_unit import sapq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             func,
	input  logic [31:0]      key_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             accepted,
	output logic [31:0]      front_key,
	output logic             not_empty,
	output logic [CNT_W-1:0] entry_count
);

	sapq_cmd_t  cmd;
	sapq_stat_t stat;

	sapq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sapq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.key_in      (key_in),
		.stat        (stat),
		.accepted    (accepted),
		.front_key   (front_key),
		.not_empty   (not_empty),
		.entry_count (entry_count)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= CNT_W'(CAPACITY)))
		else $error("entry count beyond capacity");

	a_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (not_empty == (entry_count != '0)))
		else $error("non-empty flag disagrees with count");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while result stalled");

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("input beat without result");

endmodule
